[rtl/dsi_pkg.sv]
`timescale 1ns / 1ps
// dsi_pkg: shared types and character codes for the decimal string to integer block
// no dependencies

package dsi_pkg;

	localparam int OUT_WIDTH           = 64;
	localparam int DEFAULT_VALUE_WIDTH = 64;

	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// one input beat
	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} beat_t;

endpackage

[rtl/decimal_string_to_int64.sv]
`timescale 1ns / 1ps
// Decimal text to signed integer converter, one text byte per beat. Leading
// whitespace is skipped, an optional sign is taken, digits accumulate with an
// exact range check on VALUE_WIDTH bits, and the first other byte ends the
// conversion. A result beat follows each byte marked last: the value sign-extended
// to 64 bits (0 on overflow or no digits) and the overflow flag. One byte is
// taken every cycle, but a last byte stalls in the input register while the
// previous result beat waits. From the input register a byte updates the parse
// state and, when marked last, loads the result register that offers the beat.
// The rate is set by the parse state loop, one shift-add and range check per cycle.
// depends on dsi_pkg, dsi_accum

module decimal_string_to_int64 import dsi_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  text_byte,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [OUT_WIDTH-1:0] int_value,
	output logic                        overflowed
);

	logic                          valid_s1;
	beat_t                         beat_s1;
	logic                          adv_s1;
	logic signed [VALUE_WIDTH-1:0] res_value;
	logic                          res_overflow;
	logic                          out_valid_q;
	logic signed [OUT_WIDTH-1:0]   int_value_q;
	logic                          overflowed_q;

	assign adv_s1   = valid_s1 && (!beat_s1.last_byte || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1.text_byte <= text_byte;
			beat_s1.last_byte <= last_byte;
		end
	end

	dsi_accum #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv_s1),
		.beat        (beat_s1),
		.res_value   (res_value),
		.res_overflow(res_overflow)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && beat_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && beat_s1.last_byte) begin
			int_value_q  <= OUT_WIDTH'(res_value);
			overflowed_q <= res_overflow;
		end
	end

	assign out_valid  = out_valid_q;
	assign int_value  = int_value_q;
	assign overflowed = overflowed_q;

endmodule

[rtl/dsi_accum.sv]
`timescale 1ns / 1ps
// dsi_accum: parse state and signed times-ten accumulator with range check
// depends on dsi_pkg

module dsi_accum import dsi_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  beat_t                         beat,
	output logic signed [VALUE_WIDTH-1:0] res_value,
	output logic                          res_overflow
);

	localparam int EXT_WIDTH = VALUE_WIDTH + 5;

	localparam logic [1:0] PH_SPACE  = 2'd0;
	localparam logic [1:0] PH_DIGITS = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	logic [1:0]                   phase_q, phase_nxt;
	logic                         neg_q, neg_nxt;
	logic signed [VALUE_WIDTH-1:0] acc_q, acc_nxt;
	logic                         ovf_q, ovf_nxt;

	logic                         is_blank, is_digit, is_sign, take;
	logic [3:0]                   digit;
	logic signed [EXT_WIDTH-1:0]  acc_ext, digit_ext, term, prod;
	logic [EXT_WIDTH-VALUE_WIDTH:0] top_bits;
	logic                         range_bad;

	always_comb begin
		is_blank = ((beat.text_byte >= CHAR_TAB) && (beat.text_byte <= CHAR_CR))
			|| (beat.text_byte == CHAR_SPACE);
		is_digit = (beat.text_byte >= CHAR_ZERO) && (beat.text_byte <= CHAR_NINE);
		is_sign  = (beat.text_byte == CHAR_MINUS) || (beat.text_byte == CHAR_PLUS);
		digit    = 4'(beat.text_byte - CHAR_ZERO);

		// accumulate toward negative after a minus sign
		acc_ext   = EXT_WIDTH'(acc_q);
		digit_ext = {{(EXT_WIDTH-4){1'b0}}, digit};
		term      = neg_q ? -digit_ext : digit_ext;
		prod      = (acc_ext <<< 3) + (acc_ext <<< 1) + term;
		top_bits  = prod[EXT_WIDTH-1:VALUE_WIDTH-1];
		range_bad = !((&top_bits) || !(|top_bits));

		phase_nxt = phase_q;
		neg_nxt   = neg_q;
		acc_nxt   = acc_q;
		ovf_nxt   = ovf_q;
		take      = 1'b0;

		unique case (phase_q)
			PH_SPACE: begin
				if (is_blank) begin
					phase_nxt = PH_SPACE;
				end else if (is_sign) begin
					neg_nxt   = (beat.text_byte == CHAR_MINUS);
					phase_nxt = PH_DIGITS;
				end else if (is_digit) begin
					phase_nxt = PH_DIGITS;
					take      = 1'b1;
				end else begin
					phase_nxt = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					take = 1'b1;
				end else begin
					phase_nxt = PH_DONE;
				end
			end
			default: begin
				phase_nxt = phase_q;
			end
		endcase

		if (take) begin
			if (range_bad) begin
				ovf_nxt   = 1'b1;
				acc_nxt   = '0;
				phase_nxt = PH_DONE;
			end else begin
				acc_nxt = prod[VALUE_WIDTH-1:0];
			end
		end

		res_value    = acc_nxt;
		res_overflow = ovf_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (fire) begin
			if (beat.last_byte) begin
				phase_q <= PH_SPACE;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_nxt;
				neg_q   <= neg_nxt;
				acc_q   <= acc_nxt;
				ovf_q   <= ovf_nxt;
			end
		end
	end

endmodule

[rtl/dsi_checker.sv]
`timescale 1ns / 1ps
// dsi_checker: port-level checks for the decimal string to integer block
// depends on dsi_pkg; bound to decimal_string_to_int64

module dsi_checker import dsi_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [7:0]                  text_byte,
	input logic                        last_byte,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic signed [OUT_WIDTH-1:0] int_value,
	input logic                        overflowed
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(int_value) && $stable(overflowed))
		else $error("result beat changed while stalled");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflowed |-> int_value == '0)
		else $error("overflow result not zero");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int_value[OUT_WIDTH-1:VALUE_WIDTH-1] == '0)
			|| (int_value[OUT_WIDTH-1:VALUE_WIDTH-1] == '1))
		else $error("result outside value range");

	// with no pending result the input side never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

endmodule

bind decimal_string_to_int64 dsi_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_dsi_checker (.*);
